>>> rtl/sesch_pkg.sv
`default_nettype none

package sesch_pkg;

  // Default build parameters
  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned CYL_BITS_DEF    = 10;

  // Fixed field widths on the stream ports
  localparam int unsigned CYL_FIELD_W  = 10;
  localparam int unsigned DIST_FIELD_W = 10;
  localparam int unsigned TOT_FIELD_W  = 32;
  localparam int unsigned CNT_FIELD_W  = 6;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 64;

  // Opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_ADDED    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SERVED   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;        // capture the incoming item
    logic                scan_start;  // clear index and best-candidate trackers
    logic                step;        // advance slot index
    logic                rd_en;       // read slot at index into the compare stage
    logic                commit;      // update state and load the result register
    logic [STATUS_W-1:0] code;        // status of the committed result
  } sesch_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_serve;
    logic tbl_full;
    logic tbl_empty;
    logic slot_free;
    logic idx_last;
    logic out_free;
  } sesch_sts_t;

endpackage

`default_nettype wire

>>> rtl/scan_elevator_disk_scheduler_unit.sv
// Sequence, from acceptance to result valid: a rejected add or an empty serve commits from
//   dispatch; an add walks to the lowest free slot and commits there; a serve scans every
//   slot (one slot memory read per cycle), then drains the compare stage and commits.
// Throughput: one item at a time; each commit waits for a free result register. The next
//   item can be accepted once the result is loaded, even while it waits on m_axis_tready.
// Reset: asynchronous, active low; clears valid bits, head, direction, totals at once.
`default_nettype none

module scan_elevator_disk_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = sesch_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned CYL_BITS    = sesch_pkg::CYL_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] cylinder, [15:10] zero
  input  logic [sesch_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] opcode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] served_cylinder, [19:10] seek_distance, [51:20] total_seek,
  // [52] moving_down, [58:53] pending_count, [63:59] zero
  output logic [sesch_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [sesch_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import sesch_pkg::*;

  sesch_cmd_t cmd;
  sesch_sts_t sts;

  logic [CYL_FIELD_W-1:0]  served_cylinder;
  logic [DIST_FIELD_W-1:0] seek_distance;
  logic [TOT_FIELD_W-1:0]  total_seek;
  logic                    moving_down;
  logic [CNT_FIELD_W-1:0]  pending_count;

  // Sequencer
  sesch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot table, compare stage and result register
  sesch_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CYL_BITS    (CYL_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (s_axis_tuser),
    .cylinder_i        (s_axis_tdata[CYL_FIELD_W-1:0]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .status_o          (m_axis_tuser),
    .served_cylinder_o (served_cylinder),
    .seek_distance_o   (seek_distance),
    .total_seek_o      (total_seek),
    .moving_down_o     (moving_down),
    .pending_count_o   (pending_count)
  );

  // Result packing, lowest field first
  assign m_axis_tdata = {5'b0, pending_count, moving_down, total_seek,
                         seek_distance, served_cylinder};

endmodule

`default_nettype wire

>>> rtl/sesch_ctrl.sv
`default_nettype none

module sesch_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sesch_pkg::sesch_sts_t sts_i,
  output sesch_pkg::sesch_cmd_t cmd_o
);
  import sesch_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_ADD      = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_DRAIN    = 3'd4;
  localparam logic [2:0] ST_COMMIT   = 3'd5;

  logic [2:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.code = STATUS_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts_i.op_serve) begin
          if (sts_i.tbl_full) begin
            if (sts_i.out_free) begin
              cmd_o.commit = 1'b1;
              cmd_o.code   = STATUS_REJECTED;
              state_d      = ST_IDLE;
            end
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_ADD;
          end
        end else begin
          if (sts_i.tbl_empty) begin
            if (sts_i.out_free) begin
              cmd_o.commit = 1'b1;
              cmd_o.code   = STATUS_NONE;
              state_d      = ST_IDLE;
            end
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      // walk to the lowest free slot; one is known to exist
      ST_ADD: begin
        if (sts_i.slot_free) begin
          if (sts_i.out_free) begin
            cmd_o.commit = 1'b1;
            cmd_o.code   = STATUS_ADDED;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.step  = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last slot read is compared here
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          cmd_o.code   = STATUS_SERVED;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sesch_dp.sv
`default_nettype none

module sesch_dp #(
  parameter int unsigned QUEUE_DEPTH = sesch_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned CYL_BITS    = sesch_pkg::CYL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sesch_pkg::sesch_cmd_t                cmd_i,
  output sesch_pkg::sesch_sts_t                sts_o,
  input  logic                                 opcode_i,
  input  logic [sesch_pkg::CYL_FIELD_W-1:0]    cylinder_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sesch_pkg::STATUS_W-1:0]       status_o,
  output logic [sesch_pkg::CYL_FIELD_W-1:0]    served_cylinder_o,
  output logic [sesch_pkg::DIST_FIELD_W-1:0]   seek_distance_o,
  output logic [sesch_pkg::TOT_FIELD_W-1:0]    total_seek_o,
  output logic                                 moving_down_o,
  output logic [sesch_pkg::CNT_FIELD_W-1:0]    pending_count_o
);
  import sesch_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Item capture
  logic                op_q;
  logic [CYL_BITS-1:0] cyl_q;
  logic [31:0]         cyl_ext;

  // Architectural state
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [CYL_BITS-1:0]    slot_mem [QUEUE_DEPTH];
  logic [CYL_BITS-1:0]    head_q, head_d;
  logic                   dir_q, dir_d;
  logic [TOT_FIELD_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]       pending_q, pending_d;

  // Scan index and compare stage
  logic [IDX_W-1:0]    idx_q;
  logic                rd_vld_q;
  logic [CYL_BITS-1:0] rd_cyl_q;
  logic [IDX_W-1:0]    rd_idx_q;

  // Best candidates ahead of and behind the head
  logic                fa_q, fb_q;
  logic [CYL_BITS-1:0] a_cyl_q, b_cyl_q, a_dist_q, b_dist_q;
  logic [IDX_W-1:0]    a_idx_q, b_idx_q;

  // Compare and commit logic
  logic                c_ge, c_gt, c_ahead, upd_a, upd_b;
  logic [CYL_BITS-1:0] c_dist;
  logic [CYL_BITS-1:0] sel_cyl, sel_dist, res_dist;
  logic [IDX_W-1:0]    sel_idx;
  logic [TOT_FIELD_W:0] total_sum;

  // Result register
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    o_status_q;
  logic [CYL_BITS-1:0]    o_head_q, o_dist_q;
  logic [TOT_FIELD_W-1:0] o_total_q;
  logic                   o_dir_q;
  logic [CNT_W-1:0]       o_cnt_q;
  logic [31:0]            o_head_ext, o_dist_ext, o_cnt_ext;

  assign cyl_ext = 32'(cylinder_i);

  // Status to controller
  assign sts_o.op_serve  = (op_q == OP_SERVE);
  assign sts_o.tbl_full  = (pending_q == CNT_W'(QUEUE_DEPTH));
  assign sts_o.tbl_empty = (pending_q == '0);
  assign sts_o.slot_free = !valid_q[idx_q];
  assign sts_o.idx_last  = (idx_q == IDX_W'(QUEUE_DEPTH - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Item capture, masked to the cylinder width
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      cyl_q <= cyl_ext[CYL_BITS-1:0];
    end
  end

  // Slot index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.scan_start) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Slot memory: written on add, read one slot per cycle during a serve scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && cmd_i.code == STATUS_ADDED) begin
      slot_mem[idx_q] <= cyl_q;
    end
    if (cmd_i.rd_en) begin
      rd_cyl_q <= slot_mem[idx_q];
      rd_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en && valid_q[idx_q];
    end
  end

  // Distance and side of the slot in the compare stage
  assign c_ge    = (rd_cyl_q >= head_q);
  assign c_gt    = (rd_cyl_q > head_q);
  assign c_dist  = c_ge ? (rd_cyl_q - head_q) : (head_q - rd_cyl_q);
  assign c_ahead = dir_q ? !c_gt : c_ge;
  assign upd_a   = rd_vld_q && c_ahead && (!fa_q || (c_dist < a_dist_q));
  assign upd_b   = rd_vld_q && !c_ahead && (!fb_q || (c_dist < b_dist_q));

  // Best-candidate trackers; strict compare keeps the lowest slot on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q <= 1'b0;
      fb_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      fa_q <= 1'b0;
      fb_q <= 1'b0;
    end else begin
      if (upd_a) fa_q <= 1'b1;
      if (upd_b) fb_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_a) begin
      a_cyl_q  <= rd_cyl_q;
      a_dist_q <= c_dist;
      a_idx_q  <= rd_idx_q;
    end
    if (upd_b) begin
      b_cyl_q  <= rd_cyl_q;
      b_dist_q <= c_dist;
      b_idx_q  <= rd_idx_q;
    end
  end

  // Pick: ahead first, otherwise reverse and take the nearest behind
  assign sel_cyl   = fa_q ? a_cyl_q : b_cyl_q;
  assign sel_dist  = fa_q ? a_dist_q : b_dist_q;
  assign sel_idx   = fa_q ? a_idx_q : b_idx_q;
  assign total_sum = (TOT_FIELD_W + 1)'(total_q) + (TOT_FIELD_W + 1)'(sel_dist);

  // Next architectural state for the committed item
  always_comb begin
    head_d    = head_q;
    dir_d     = dir_q;
    total_d   = total_q;
    pending_d = pending_q;
    res_dist  = '0;
    case (cmd_i.code)
      STATUS_ADDED: begin
        pending_d = pending_q + 1'b1;
      end
      STATUS_SERVED: begin
        head_d    = sel_cyl;
        dir_d     = fa_q ? dir_q : !dir_q;
        total_d   = total_sum[TOT_FIELD_W] ? '1 : total_sum[TOT_FIELD_W-1:0];
        pending_d = pending_q - 1'b1;
        res_dist  = sel_dist;
      end
      default: begin
        res_dist = '0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      head_q    <= '0;
      dir_q     <= 1'b0;
      total_q   <= '0;
      pending_q <= '0;
    end else if (cmd_i.commit) begin
      head_q    <= head_d;
      dir_q     <= dir_d;
      total_q   <= total_d;
      pending_q <= pending_d;
      if (cmd_i.code == STATUS_ADDED) begin
        valid_q[idx_q] <= 1'b1;
      end else if (cmd_i.code == STATUS_SERVED) begin
        valid_q[sel_idx] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      o_status_q <= cmd_i.code;
      o_head_q   <= head_d;
      o_dist_q   <= res_dist;
      o_total_q  <= total_d;
      o_dir_q    <= dir_d;
      o_cnt_q    <= pending_d;
    end
  end

  assign o_head_ext = 32'(o_head_q);
  assign o_dist_ext = 32'(o_dist_q);
  assign o_cnt_ext  = 32'(o_cnt_q);

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign served_cylinder_o = o_head_ext[CYL_FIELD_W-1:0];
  assign seek_distance_o   = o_dist_ext[DIST_FIELD_W-1:0];
  assign total_seek_o      = o_total_q;
  assign moving_down_o     = o_dir_q;
  assign pending_count_o   = o_cnt_ext[CNT_FIELD_W-1:0];

  // Pending count tracks the occupied slots
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) == $countones(valid_q))
    else $error("pending count differs from occupied slots");

  // An add only lands in a free slot
  a_add_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && cmd_i.code == STATUS_ADDED) |-> !valid_q[idx_q])
    else $error("add written over an occupied slot");

  // A serve always has a candidate and removes an occupied slot
  a_srv_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && cmd_i.code == STATUS_SERVED) |-> ((fa_q || fb_q) && valid_q[sel_idx]))
    else $error("serve committed without a pending candidate");

  // A commit never overwrites a result that was not taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overrun");

endmodule

`default_nettype wire
